/* rtl/core/tabular_q_learning_step_top_macros.svh */
// Assertion helpers used by the checker file of this block.
// Every property is sampled on the rising clock edge and is ignored while reset is held.
`ifndef TABULAR_Q_LEARNING_STEP_TOP_MACROS_SVH
`define TABULAR_Q_LEARNING_STEP_TOP_MACROS_SVH

// Same-cycle implication.
`define TQLS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TQLS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tqls_pkg.sv */
`default_nettype none

package tqls_pkg;

  localparam int unsigned N_ACT     = 9;
  localparam int unsigned TAB_DEPTH = N_ACT * N_ACT;
  localparam int unsigned ADDR_W    = $clog2(TAB_DEPTH);
  localparam int unsigned CNT_W     = $clog2(N_ACT + 1);

  localparam logic [3:0] LAST_ACT = 4'(N_ACT - 1);

  localparam logic signed [7:0] SCAN_FLOOR  = -8'sd100;
  localparam logic signed [7:0] ZERO_REWARD = -8'sd5;

  localparam logic [7:0] ANGLE_0   = 8'd0;
  localparam logic [7:0] ANGLE_90  = 8'd90;
  localparam logic [7:0] ANGLE_180 = 8'd180;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLOIT_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 2'd2;

  localparam logic [3:0] THR_RESET   = 4'd9;
  localparam logic [4:0] ALPHA_RESET = 5'd8;
  localparam logic [4:0] GAMMA_RESET = 5'd14;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START,
    ST_SCAN_STATE,
    ST_TAKE_GREEDY,
    ST_SCAN_ACTION,
    ST_READ_OLD,
    ST_CALC_TD,
    ST_CALC_INC,
    ST_WRITE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic start_set;
    logic scan_en;
    logic scan_next_row;
    logic take_greedy;
    logic take_pick;
    logic calc_td;
    logic calc_inc;
    logic write_upd;
    logic out_load;
  } tqls_cmd_t;

  typedef struct packed {
    logic is_start;
    logic greedy;
    logic scan_last;
    logic out_free;
  } tqls_sts_t;

  function automatic logic [7:0] servo_a_angle(input logic [3:0] act);
    logic [7:0] ang;
    unique case (act)
      4'd0, 4'd1, 4'd2: ang = ANGLE_0;
      4'd3, 4'd4, 4'd5: ang = ANGLE_90;
      default:          ang = ANGLE_180;
    endcase
    return ang;
  endfunction

  function automatic logic [7:0] servo_b_angle(input logic [3:0] act);
    logic [7:0] ang;
    unique case (act)
      4'd0, 4'd3, 4'd6: ang = ANGLE_0;
      4'd1, 4'd4, 4'd7: ang = ANGLE_90;
      default:          ang = ANGLE_180;
    endcase
    return ang;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tqls_ctrl.sv */
`default_nettype none

module tqls_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire tqls_pkg::tqls_sts_t  sts_i,
  output tqls_pkg::tqls_cmd_t       cmd_o
);
  import tqls_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (sts_i.is_start) begin
          state_d = ST_START;
        end else if (sts_i.greedy) begin
          state_d = ST_SCAN_STATE;
        end else begin
          state_d = ST_SCAN_ACTION;
        end
      end
      ST_START:       state_d = ST_OUT;
      ST_SCAN_STATE: begin
        if (sts_i.scan_last) begin
          state_d = ST_TAKE_GREEDY;
        end
      end
      ST_TAKE_GREEDY: state_d = ST_SCAN_ACTION;
      ST_SCAN_ACTION: begin
        if (sts_i.scan_last) begin
          state_d = ST_READ_OLD;
        end
      end
      ST_READ_OLD:    state_d = ST_CALC_TD;
      ST_CALC_TD:     state_d = ST_CALC_INC;
      ST_CALC_INC:    state_d = ST_WRITE;
      ST_WRITE:       state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECIDE:      cmd_o.take_pick = !sts_i.is_start && !sts_i.greedy;
      ST_START:       cmd_o.start_set = 1'b1;
      ST_SCAN_STATE:  cmd_o.scan_en = 1'b1;
      ST_TAKE_GREEDY: cmd_o.take_greedy = 1'b1;
      ST_SCAN_ACTION: begin
        cmd_o.scan_en       = 1'b1;
        cmd_o.scan_next_row = 1'b1;
      end
      ST_CALC_TD:     cmd_o.calc_td = 1'b1;
      ST_CALC_INC:    cmd_o.calc_inc = 1'b1;
      ST_WRITE:       cmd_o.write_upd = 1'b1;
      ST_OUT:         cmd_o.out_load = sts_i.out_free;
      default:        cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/tqls_datapath.sv */
`default_nettype none

module tqls_datapath #(
  parameter int unsigned QB = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tqls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tqls_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_cmd_i,
  input  wire logic [3:0]                          in_draw_i,
  input  wire logic [3:0]                          in_pick_i,
  input  wire logic signed [7:0]                   in_delta_i,
  input  wire tqls_pkg::tqls_cmd_t                 cmd_i,
  output tqls_pkg::tqls_sts_t                      sts_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [3:0]                               out_action_o,
  output logic [7:0]                               out_servo_a_o,
  output logic [7:0]                               out_servo_b_o,
  output logic                                     out_explored_o,
  output logic signed [7:0]                        out_value_o
);
  import tqls_pkg::*;

  localparam int unsigned TW = QB + 8;
  localparam int unsigned PW = TW + 6;
  localparam logic signed [PW-1:0] QMAX = PW'((1 << (QB - 1)) - 1);
  localparam logic signed [PW-1:0] QMIN = -QMAX - PW'(1);
  localparam logic signed [PW-1:0] ROUND_ADJ = PW'(255);

  logic [3:0] thr_q;
  logic [4:0] alpha_q, gamma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      alpha_q <= ALPHA_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXPLOIT_THR: thr_q   <= cfg_data_i[3:0];
        CFG_LEARN_RATE:  alpha_q <= cfg_data_i;
        CFG_DISCOUNT:    gamma_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic                cmd_q;
  logic [3:0]          draw_q, pick_q;
  logic signed [7:0]   delta_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_cmd_i;
      draw_q  <= in_draw_i;
      pick_q  <= (in_pick_i > LAST_ACT) ? LAST_ACT : in_pick_i;
      delta_q <= in_delta_i;
    end
  end

  logic [3:0] present_q, act_q;
  logic       expl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (cmd_i.start_set) begin
      present_q <= pick_q;
    end else if (cmd_i.write_upd) begin
      present_q <= act_q;
    end
  end

  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [3:0]       best_idx_q;
  logic signed [QB-1:0] best_q;

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.start_set || cmd_i.take_pick) begin
      act_q  <= pick_q;
      expl_q <= !cmd_i.start_set;
    end else if (cmd_i.take_greedy) begin
      act_q  <= best_idx_q;
      expl_q <= 1'b0;
    end
  end

  // Table address: row times nine plus column.
  logic [3:0]        row, col;
  logic [ADDR_W-1:0] addr;
  logic              scan_issue;

  assign scan_issue = scan_cnt_q < CNT_W'(N_ACT);
  assign row  = (cmd_i.scan_en && cmd_i.scan_next_row) ? act_q : present_q;
  assign col  = cmd_i.scan_en ? (scan_issue ? 4'(scan_cnt_q) : 4'd0) : act_q;
  assign addr = ADDR_W'({row, 3'b000}) + ADDR_W'(row) + ADDR_W'(col);

  logic [QB-1:0]        mem_q [TAB_DEPTH];
  logic [QB-1:0]        rd_data_q;
  logic [TAB_DEPTH-1:0] vld_q;
  logic                 rd_vld_q;
  logic signed [QB-1:0] new_val;
  logic signed [QB-1:0] q_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_upd) begin
      mem_q[addr] <= new_val;
    end
    rd_data_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start_set) begin
        vld_q <= '0;
      end else if (cmd_i.write_upd) begin
        vld_q[addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr];
    end
  end

  assign q_rd = rd_vld_q ? $signed(rd_data_q) : '0;

  always_comb begin
    scan_cnt_d = '0;
    if (cmd_i.scan_en && scan_issue) begin
      scan_cnt_d = scan_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else begin
      scan_cnt_q <= scan_cnt_d;
    end
  end

  // The first scan cycle only issues a read, so it also seeds the running maximum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if (scan_cnt_q == '0) begin
        best_q     <= QB'(SCAN_FLOOR);
        best_idx_q <= '0;
      end else if (q_rd > best_q) begin
        best_q     <= q_rd;
        best_idx_q <= 4'(scan_cnt_q - CNT_W'(1));
      end
    end
  end

  logic signed [7:0]    half, reward;
  logic signed [QB+5:0] gamma_prod;
  logic signed [TW-1:0] td_q;
  logic signed [QB-1:0] old_q;
  logic signed [PW-1:0] prod_q, prod_adj, inc, sum;

  assign half       = (delta_q + $signed({7'd0, delta_q[7]})) >>> 1;
  assign reward     = (half == 8'sd0) ? ZERO_REWARD : half;
  assign gamma_prod = $signed({1'b0, gamma_q}) * best_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_td) begin
      old_q <= q_rd;
      td_q  <= (TW'(reward) <<< 4) + TW'(gamma_prod) - (TW'(q_rd) <<< 4);
    end
    if (cmd_i.calc_inc) begin
      prod_q <= $signed({1'b0, alpha_q}) * td_q;
    end
  end

  // Division by 256 rounds toward zero.
  assign prod_adj = prod_q + (prod_q[PW-1] ? ROUND_ADJ : '0);
  assign inc      = prod_adj >>> 8;
  assign sum      = PW'(old_q) + inc;

  always_comb begin
    priority if (sum > QMAX) begin
      new_val = QMAX[QB-1:0];
    end else if (sum < QMIN) begin
      new_val = QMIN[QB-1:0];
    end else begin
      new_val = sum[QB-1:0];
    end
  end

  logic signed [7:0] res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_set) begin
      res_q <= '0;
    end else if (cmd_i.write_upd) begin
      res_q <= new_val[7:0];
    end
  end

  logic       out_valid_q;
  logic [3:0] out_act_q;
  logic       out_expl_q;
  logic signed [7:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_act_q  <= act_q;
      out_expl_q <= expl_q;
      out_val_q  <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_action_o   = out_act_q;
  assign out_servo_a_o  = servo_a_angle(out_act_q);
  assign out_servo_b_o  = servo_b_angle(out_act_q);
  assign out_explored_o = out_expl_q;
  assign out_value_o    = out_val_q;

  assign sts_o.is_start  = (cmd_q == CMD_START);
  assign sts_o.greedy    = draw_q < thr_q;
  assign sts_o.scan_last = cmd_i.scan_en && !scan_issue;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/core/tabular_q_learning_step_top.sv */
// Tabular Q-learning step engine with epsilon-greedy action choice. It keeps a nine by
// nine table of signed Q values and a present state. A transfer with tuser low is a
// start: it clears the table and loads the state from random_pick, and its result shows
// that state with explored and updated_value at zero. A transfer with tuser high is a
// learning step: it chooses an action, maps it to two servo angles and applies the
// temporal-difference update to the table. One item is worked on at a time. A start
// scans no row, an exploring step one and a greedy step two; each nine-entry row is
// scanned through the single table read port. The user must write configuration
// through cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module tabular_q_learning_step_top #(
  parameter int unsigned Q_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tqls_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tqls_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // explore_draw [3:0], random_pick [7:4], count_delta [15:8]
  input  wire logic [tqls_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd [0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // action [3:0], servo_a_angle [11:4], servo_b_angle [19:12], updated_value [27:20]
  output logic [tqls_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // explored [0]
  output logic                                     m_axis_tuser
);
  import tqls_pkg::*;

  tqls_cmd_t cmd;
  tqls_sts_t sts;

  logic [3:0]        out_action;
  logic [7:0]        out_servo_a, out_servo_b;
  logic signed [7:0] out_value;

  tqls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tqls_datapath #(
    .QB (Q_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_cmd_i       (s_axis_tuser),
    .in_draw_i      (s_axis_tdata[3:0]),
    .in_pick_i      (s_axis_tdata[7:4]),
    .in_delta_i     ($signed(s_axis_tdata[15:8])),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_action_o   (out_action),
    .out_servo_a_o  (out_servo_a),
    .out_servo_b_o  (out_servo_b),
    .out_explored_o (m_axis_tuser),
    .out_value_o    (out_value)
  );

  assign m_axis_tdata = {4'd0, out_value, out_servo_b, out_servo_a, out_action};

endmodule

`default_nettype wire

/* rtl/core/tqls_checker.sv */
`default_nettype none

`include "tabular_q_learning_step_top_macros.svh"

module tqls_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [tqls_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  `TQLS_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "Input accepted again right after a transfer.")

  `TQLS_ASSERT_IMP(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready),
    "Result appeared without an item in progress.")

  `TQLS_ASSERT_IMP(a_action_range, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd8,
    "Result action is outside the grid.")

  `TQLS_ASSERT_IMP(a_angle_codes, m_axis_tvalid,
    (m_axis_tdata[11:4] == 8'd0 || m_axis_tdata[11:4] == 8'd90 ||
     m_axis_tdata[11:4] == 8'd180) &&
    (m_axis_tdata[19:12] == 8'd0 || m_axis_tdata[19:12] == 8'd90 ||
     m_axis_tdata[19:12] == 8'd180),
    "Servo angle is not a grid angle.")

  `TQLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "Stalled result changed.")

endmodule

bind tabular_q_learning_step_top tqls_checker u_tqls_checker (.*);

`default_nettype wire
